// File: src/sbcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcp_pkg
// Shared types, constants and register map of the side band color profile.
// ----------------------------------------------------------------------------
package sbcp_pkg;

   // default parameter values
   localparam int MAX_LATERAL_DEFAULT = 64;
   localparam int MAX_COLUMNS_DEFAULT = 4096;
   localparam int COUNT_BITS_DEFAULT  = 20;

   // fixed field widths
   localparam int CHANNELS  = 3;
   localparam int SIDES_CH  = 2 * CHANNELS;
   localparam int CHAN_W    = 3;
   localparam int PIXEL_W   = 8;
   localparam int COLUMN_W  = 12;
   localparam int OFFSET_W  = 7;
   localparam int LATERAL_W = 7;
   localparam int WIDTH_W   = 13;
   localparam int DIFF_W    = 11;
   localparam int SCORE_W   = 16;
   localparam int QUOT_W    = 8;

   // stream packing
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;

   // config port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LATERAL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_L_RED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_L_GREEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_L_BLUE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_R_RED   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_R_GREEN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_R_BLUE  = 3'd7;

   localparam logic [LATERAL_W-1:0] LATERAL_RESET = 7'd8;
   localparam logic [WIDTH_W-1:0]   WIDTH_RESET   = 13'd640;

   // sample queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_LVL_W = QUEUE_PTR_W + 1;

   // score: round(1024*(180-d)/45) through a reciprocal multiply
   localparam logic [DIFF_W-1:0] SCORE_RANGE = 11'd180;
   localparam int                SCALE_X_W   = 21;
   localparam int                RECIP_W     = 19;
   localparam int                PROD_W      = SCALE_X_W + RECIP_W;
   localparam int                RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0]   RECIP_MULT = 19'd372827;
   localparam logic [SCALE_X_W-1:0] ROUND_BIAS = 21'd22;
   localparam logic [SCALE_X_W-1:0] SCORE_DIV  = 21'd45;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // classified sample travelling from the front to the back
   typedef struct packed {
      logic      keep_left;
      logic      keep_right;
      logic      last;
      pixel_type red;
      pixel_type green;
      pixel_type blue;
   } sample_type;

   typedef struct packed {
      pixel_type left_red;
      pixel_type left_green;
      pixel_type left_blue;
      pixel_type right_red;
      pixel_type right_green;
      pixel_type right_blue;
   } ref_profile_type;

   typedef struct packed {
      pixel_type                 left_red;
      pixel_type                 left_green;
      pixel_type                 left_blue;
      pixel_type                 right_red;
      pixel_type                 right_green;
      pixel_type                 right_blue;
      logic                      left_empty;
      logic                      right_empty;
      logic [DIFF_W-1:0]         difference_sum;
      logic signed [SCORE_W-1:0] similarity_score;
   } result_type;

   typedef struct packed {
      logic busy;
      logic pop;
      logic finishing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DIFF,
      ST_SCALE,
      ST_ROUND
   } back_state_type;

endpackage

// File: src/side_band_color_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// side_band_color_profile
// Mean color of the bands left and right of a line, scored against a profile.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel sample per transfer; req_tlast closes a line.
//   Samples are classified on entry and queued (four entries) ahead of the
//   accumulators, which take one sample per cycle while not dividing or scoring.
//   rsp_* carries one result per line, produced only for the req_tlast sample.
//   After the last sample leaves the queue, the six channel means go through
//   one shared divider (eight quotient bits), then the difference, scale and
//   round steps build the score; the round step loads the output register and
//   raises rsp_tvalid, waiting while an earlier result is still held. Samples
//   of the next line queue up meanwhile, up to four.
//   The result sits in an output register; while rsp_tready is low the block
//   keeps accumulating the next line and only the next result waits.
//   csr_* is the register port; write registers only while the block is idle.
//   Reset clears the sums, counts, queue and output, and loads the register
//   defaults (half width 8, image width 640, reference colors 0).
// ----------------------------------------------------------------------------
module side_band_color_profile #(
   parameter int MAX_LATERAL = sbcp_pkg::MAX_LATERAL_DEFAULT,
   parameter int MAX_COLUMNS = sbcp_pkg::MAX_COLUMNS_DEFAULT,
   parameter int COUNT_BITS  = sbcp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // point_column, lateral_offset, pixel_red, pixel_green, pixel_blue, zero pad
   input  logic [sbcp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_red, left_green, left_blue, right_red, right_green, right_blue,
   // difference_sum, similarity_score, zero pad
   output logic [sbcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // left_empty, right_empty
   output logic [sbcp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sbcp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sbcp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sbcp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [sbcp_pkg::LATERAL_W-1:0]     lateral_ff;
   logic [sbcp_pkg::WIDTH_W-1:0]       width_ff;
   sbcp_pkg::ref_profile_type          ref_ff;
   logic                               csr_write;
   logic [sbcp_pkg::CSR_IDX_W-1:0]     csr_index;

   sbcp_pkg::sample_type               front_sample;
   sbcp_pkg::sample_type               q_data;
   logic                               q_full;
   logic                               q_valid;
   logic [sbcp_pkg::QUEUE_LVL_W-1:0]   q_level;
   logic                               push;
   sbcp_pkg::back_status_type          back_status;
   sbcp_pkg::result_type               result;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[sbcp_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lateral_ff <= sbcp_pkg::LATERAL_RESET;
         width_ff   <= sbcp_pkg::WIDTH_RESET;
         ref_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            sbcp_pkg::CSR_LATERAL:     lateral_ff <= csr_pwdata[sbcp_pkg::LATERAL_W-1:0];
            sbcp_pkg::CSR_IMAGE_WIDTH: width_ff   <= csr_pwdata[sbcp_pkg::WIDTH_W-1:0];
            sbcp_pkg::CSR_REF_L_RED:   ref_ff.left_red    <= csr_pwdata[7:0];
            sbcp_pkg::CSR_REF_L_GREEN: ref_ff.left_green  <= csr_pwdata[7:0];
            sbcp_pkg::CSR_REF_L_BLUE:  ref_ff.left_blue   <= csr_pwdata[7:0];
            sbcp_pkg::CSR_REF_R_RED:   ref_ff.right_red   <= csr_pwdata[7:0];
            sbcp_pkg::CSR_REF_R_GREEN: ref_ff.right_green <= csr_pwdata[7:0];
            sbcp_pkg::CSR_REF_R_BLUE:  ref_ff.right_blue  <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         sbcp_pkg::CSR_LATERAL:     csr_prdata = 32'(lateral_ff);
         sbcp_pkg::CSR_IMAGE_WIDTH: csr_prdata = 32'(width_ff);
         sbcp_pkg::CSR_REF_L_RED:   csr_prdata = 32'(ref_ff.left_red);
         sbcp_pkg::CSR_REF_L_GREEN: csr_prdata = 32'(ref_ff.left_green);
         sbcp_pkg::CSR_REF_L_BLUE:  csr_prdata = 32'(ref_ff.left_blue);
         sbcp_pkg::CSR_REF_R_RED:   csr_prdata = 32'(ref_ff.right_red);
         sbcp_pkg::CSR_REF_R_GREEN: csr_prdata = 32'(ref_ff.right_green);
         sbcp_pkg::CSR_REF_R_BLUE:  csr_prdata = 32'(ref_ff.right_blue);
         default:                   csr_prdata = '0;
      endcase
   end

   // classify incoming samples
   sbcp_front #(
      .MAX_LATERAL (MAX_LATERAL),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .point_column       (req_tdata[11:0]),
      .lateral_offset     ($signed(req_tdata[18:12])),
      .pixel_red          (req_tdata[26:19]),
      .pixel_green        (req_tdata[34:27]),
      .pixel_blue         (req_tdata[42:35]),
      .last_sample        (req_tlast),
      .lateral_half_width (lateral_ff),
      .image_width        (width_ff),
      .sample             (front_sample)
   );

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   sbcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_sample),
      .full      (q_full),
      .pop       (back_status.pop),
      .valid     (q_valid),
      .pop_data  (q_data),
      .level     (q_level)
   );

   // accumulate and build the result
   sbcp_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .ref_profile (ref_ff),
      .status      (back_status),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (result)
   );

   // result packing
   assign rsp_tdata = {5'b0,
                       result.similarity_score,
                       result.difference_sum,
                       result.right_blue,
                       result.right_green,
                       result.right_red,
                       result.left_blue,
                       result.left_green,
                       result.left_red};
   assign rsp_tuser = {result.right_empty, result.left_empty};

`ifndef SYNTH
   // queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      q_level <= sbcp_pkg::QUEUE_LVL_W'(sbcp_pkg::QUEUE_DEPTH))
      else $error("sample queue level above depth");

   // a lone transfer into the queue raises its level by one
   assert property (@(posedge clock) disable iff (reset)
      (push && !back_status.pop) |=> (q_level == $past(q_level) + 1'b1))
      else $error("sample queue level did not follow a push");

   // a result appears only out of the rounding step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_status.finishing))
      else $error("result raised outside the rounding step");

   // the queue is not drained while the back end is dividing or scoring
   assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !back_status.pop)
      else $error("queue popped while back end busy");
`endif

endmodule

// File: src/sbcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcp_front
// Classifies an incoming sample as left, right or dropped.
// ----------------------------------------------------------------------------
module sbcp_front #(
   parameter int MAX_LATERAL = sbcp_pkg::MAX_LATERAL_DEFAULT,
   parameter int MAX_COLUMNS = sbcp_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic [sbcp_pkg::COLUMN_W-1:0]         point_column,
   input  logic signed [sbcp_pkg::OFFSET_W-1:0]  lateral_offset,
   input  sbcp_pkg::pixel_type                   pixel_red,
   input  sbcp_pkg::pixel_type                   pixel_green,
   input  sbcp_pkg::pixel_type                   pixel_blue,
   input  logic                                  last_sample,
   input  logic [sbcp_pkg::LATERAL_W-1:0]        lateral_half_width,
   input  logic [sbcp_pkg::WIDTH_W-1:0]          image_width,
   output sbcp_pkg::sample_type                  sample
);

   logic [sbcp_pkg::LATERAL_W-1:0] lat_eff;
   logic [sbcp_pkg::WIDTH_W-1:0]   width_eff;
   logic signed [8:0]              off_ext;
   logic signed [8:0]              lat_ext;
   logic signed [13:0]             target;
   logic                           in_band;
   logic                           in_image;

   // clamp the registers to the build limits
   assign lat_eff = (32'(lateral_half_width) > 32'(MAX_LATERAL)) ?
                    sbcp_pkg::LATERAL_W'(MAX_LATERAL) : lateral_half_width;
   assign width_eff = (32'(image_width) > 32'(MAX_COLUMNS)) ?
                      sbcp_pkg::WIDTH_W'(MAX_COLUMNS) : image_width;

   // offset inside [-lat, lat)
   assign off_ext = 9'(lateral_offset);
   assign lat_ext = $signed({2'b00, lat_eff});
   assign in_band = (off_ext >= -lat_ext) && (off_ext < lat_ext);

   // sampled column inside the image
   assign target   = $signed({2'b00, point_column}) + 14'(lateral_offset);
   assign in_image = !target[13] && (target[12:0] < width_eff);

   // side selection, offset zero belongs to neither side
   always_comb begin
      sample.keep_left  = in_band && in_image && lateral_offset[sbcp_pkg::OFFSET_W-1];
      sample.keep_right = in_band && in_image && !lateral_offset[sbcp_pkg::OFFSET_W-1]
                          && (lateral_offset != '0);
      sample.last       = last_sample;
      sample.red        = pixel_red;
      sample.green      = pixel_green;
      sample.blue       = pixel_blue;
   end

endmodule

// File: src/sbcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcp_queue
// Short sample queue between the classifying front and the accumulating back.
// ----------------------------------------------------------------------------
module sbcp_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  sbcp_pkg::sample_type                 push_data,
   output logic                                 full,
   input  logic                                 pop,
   output logic                                 valid,
   output sbcp_pkg::sample_type                 pop_data,
   output logic [sbcp_pkg::QUEUE_LVL_W-1:0]     level
);

   sbcp_pkg::sample_type                 entry_ff [sbcp_pkg::QUEUE_DEPTH];
   logic [sbcp_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sbcp_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sbcp_pkg::QUEUE_LVL_W-1:0]     level_ff, level_in;
   logic                                 do_push, do_pop;

   assign full     = (level_ff == sbcp_pkg::QUEUE_LVL_W'(sbcp_pkg::QUEUE_DEPTH));
   assign valid    = (level_ff != '0);
   assign level    = level_ff;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and level update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/sbcp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcp_div
// Restoring divider for a channel mean, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbcp_div #(
   parameter int COUNT_BITS = sbcp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [COUNT_BITS+7:0]         dividend,
   input  logic [COUNT_BITS-1:0]         divisor,
   output logic                          done,
   output logic [sbcp_pkg::QUOT_W-1:0]   quotient
);

   localparam int SUM_W = COUNT_BITS + 8;

   // a mean never exceeds 255, so eight quotient bits cover it
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [SUM_W-1:0]            rem_ff, rem_in;
   logic [COUNT_BITS-1:0]       den_ff, den_in;
   logic [2:0]                  bit_ff, bit_in;
   logic [sbcp_pkg::QUOT_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0]            trial;

   assign trial    = SUM_W'(den_ff) << bit_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   // one trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bit_in  = bit_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = dividend;
         den_in  = divisor;
         bit_in  = 3'd7;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            quo_in = quo_ff | (sbcp_pkg::QUOT_W'(1) << bit_ff);
         end
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      bit_ff <= bit_in;
      quo_ff <= quo_in;
   end

endmodule

// File: src/sbcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcp_back
// Accumulates classified samples and, on the last one, builds the result.
// ----------------------------------------------------------------------------
module sbcp_back #(
   parameter int COUNT_BITS = sbcp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  sbcp_pkg::sample_type        q_data,
   input  sbcp_pkg::ref_profile_type   ref_profile,
   output sbcp_pkg::back_status_type   status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sbcp_pkg::result_type        rsp_data
);

   localparam int SUM_W = COUNT_BITS + 8;
   localparam logic [sbcp_pkg::CHAN_W-1:0] LAST_CHAN =
      sbcp_pkg::CHAN_W'(sbcp_pkg::SIDES_CH - 1);
   localparam logic [sbcp_pkg::CHAN_W-1:0] RIGHT_FIRST =
      sbcp_pkg::CHAN_W'(sbcp_pkg::CHANNELS);

   sbcp_pkg::back_state_type                state_ff, state_in;
   logic [SUM_W-1:0]                        sum_ff [sbcp_pkg::SIDES_CH];
   logic [SUM_W-1:0]                        sum_in [sbcp_pkg::SIDES_CH];
   logic [COUNT_BITS-1:0]                   lcount_ff, lcount_in;
   logic [COUNT_BITS-1:0]                   rcount_ff, rcount_in;
   logic [sbcp_pkg::CHAN_W-1:0]             chan_ff, chan_in;
   sbcp_pkg::pixel_type                     mean_ff [sbcp_pkg::SIDES_CH];
   sbcp_pkg::pixel_type                     mean_in [sbcp_pkg::SIDES_CH];
   logic                                    lempty_ff, lempty_in;
   logic                                    rempty_ff, rempty_in;
   logic [sbcp_pkg::DIFF_W-1:0]             diff_ff, diff_in;
   logic                                    neg_ff, neg_in;
   logic [sbcp_pkg::SCALE_X_W-1:0]          x_ff, x_in;
   logic [sbcp_pkg::PROD_W-1:0]             prod_ff, prod_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   sbcp_pkg::result_type                    rsp_ff, rsp_in;

   logic                                    div_start;
   logic                                    div_done;
   logic [sbcp_pkg::QUOT_W-1:0]             div_quot;
   logic [COUNT_BITS-1:0]                   div_den;
   logic [sbcp_pkg::DIFF_W-1:0]             mag;
   logic [sbcp_pkg::SCORE_W-1:0]            q_est;
   logic [sbcp_pkg::SCALE_X_W-1:0]          rem_est;
   logic [sbcp_pkg::SCORE_W-1:0]            q_fix;
   logic                                    pop;

   function automatic logic [sbcp_pkg::DIFF_W-1:0] abs_diff(
      input sbcp_pkg::pixel_type a,
      input sbcp_pkg::pixel_type b
   );
      logic [sbcp_pkg::PIXEL_W-1:0] d;
      d = (a > b) ? a - b : b - a;
      return sbcp_pkg::DIFF_W'(d);
   endfunction

   // shared divider, left channels first then right
   assign div_den = (chan_ff < RIGHT_FIRST) ? lcount_ff : rcount_ff;

   sbcp_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[chan_ff]),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   // score rounding correction terms
   assign q_est   = prod_ff[sbcp_pkg::RECIP_SHIFT +: sbcp_pkg::SCORE_W];
   assign rem_est = x_ff - sbcp_pkg::SCALE_X_W'(
                    sbcp_pkg::SCALE_X_W'(q_est) * sbcp_pkg::SCORE_DIV);
   assign q_fix   = (rem_est >= sbcp_pkg::SCORE_DIV) ? q_est + 1'b1 : q_est;
   assign mag     = (diff_ff > sbcp_pkg::SCORE_RANGE) ? diff_ff - sbcp_pkg::SCORE_RANGE
                                                      : sbcp_pkg::SCORE_RANGE - diff_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign status.busy      = (state_ff != sbcp_pkg::ST_ACCUM);
   assign status.pop       = pop;
   assign status.finishing = (state_ff == sbcp_pkg::ST_ROUND);

   // sequencer: accumulate, divide six channels, difference, score
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      lcount_in    = lcount_ff;
      rcount_in    = rcount_ff;
      chan_in      = chan_ff;
      mean_in      = mean_ff;
      lempty_in    = lempty_ff;
      rempty_in    = rempty_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      pop          = 1'b0;
      case (state_ff)
         sbcp_pkg::ST_ACCUM: begin
            pop = q_valid;
            if (q_valid) begin
               if (q_data.keep_left && (lcount_ff != '1)) begin
                  sum_in[0] = sum_ff[0] + SUM_W'(q_data.red);
                  sum_in[1] = sum_ff[1] + SUM_W'(q_data.green);
                  sum_in[2] = sum_ff[2] + SUM_W'(q_data.blue);
                  lcount_in = lcount_ff + 1'b1;
               end
               if (q_data.keep_right && (rcount_ff != '1)) begin
                  sum_in[3] = sum_ff[3] + SUM_W'(q_data.red);
                  sum_in[4] = sum_ff[4] + SUM_W'(q_data.green);
                  sum_in[5] = sum_ff[5] + SUM_W'(q_data.blue);
                  rcount_in = rcount_ff + 1'b1;
               end
               if (q_data.last) begin
                  chan_in  = '0;
                  state_in = sbcp_pkg::ST_DIV_START;
               end
            end
         end
         sbcp_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = sbcp_pkg::ST_DIV_WAIT;
         end
         sbcp_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in[chan_ff] = (div_den == '0) ? '0 : div_quot;
               if (chan_ff == LAST_CHAN) begin
                  lempty_in = (lcount_ff == '0);
                  rempty_in = (rcount_ff == '0);
                  for (int i = 0; i < sbcp_pkg::SIDES_CH; i++) begin
                     sum_in[i] = '0;
                  end
                  lcount_in = '0;
                  rcount_in = '0;
                  state_in  = sbcp_pkg::ST_DIFF;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = sbcp_pkg::ST_DIV_START;
               end
            end
         end
         sbcp_pkg::ST_DIFF: begin
            diff_in = abs_diff(mean_ff[0], ref_profile.left_red)
                    + abs_diff(mean_ff[1], ref_profile.left_green)
                    + abs_diff(mean_ff[2], ref_profile.left_blue)
                    + abs_diff(mean_ff[3], ref_profile.right_red)
                    + abs_diff(mean_ff[4], ref_profile.right_green)
                    + abs_diff(mean_ff[5], ref_profile.right_blue);
            state_in = sbcp_pkg::ST_SCALE;
         end
         sbcp_pkg::ST_SCALE: begin
            // magnitude of 1024*(180-d) plus the rounding bias, times 2^24/45
            neg_in   = (diff_ff > sbcp_pkg::SCORE_RANGE);
            x_in     = {mag, 10'b0} + sbcp_pkg::ROUND_BIAS;
            prod_in  = sbcp_pkg::PROD_W'(x_in) * sbcp_pkg::PROD_W'(sbcp_pkg::RECIP_MULT);
            state_in = sbcp_pkg::ST_ROUND;
         end
         sbcp_pkg::ST_ROUND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_in.left_red         = mean_ff[0];
               rsp_in.left_green       = mean_ff[1];
               rsp_in.left_blue        = mean_ff[2];
               rsp_in.right_red        = mean_ff[3];
               rsp_in.right_green      = mean_ff[4];
               rsp_in.right_blue       = mean_ff[5];
               rsp_in.left_empty       = lempty_ff;
               rsp_in.right_empty      = rempty_ff;
               rsp_in.difference_sum   = diff_ff;
               rsp_in.similarity_score = neg_ff ? -$signed(q_fix) : $signed(q_fix);
               state_in                = sbcp_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = sbcp_pkg::ST_ACCUM;
         end
      endcase
   end

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbcp_pkg::ST_ACCUM;
         rsp_valid_ff <= 1'b0;
         lcount_ff    <= '0;
         rcount_ff    <= '0;
         for (int i = 0; i < sbcp_pkg::SIDES_CH; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcount_ff    <= lcount_in;
         rcount_ff    <= rcount_in;
         sum_ff       <= sum_in;
      end
   end

   // result datapath
   always_ff @(posedge clock) begin
      chan_ff   <= chan_in;
      mean_ff   <= mean_in;
      lempty_ff <= lempty_in;
      rempty_ff <= rempty_in;
      diff_ff   <= diff_in;
      neg_ff    <= neg_in;
      x_ff      <= x_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

endmodule
